@@ hdl/mcfs_pkg.sv @@
// ----------------------------------------------------------------------------
// Multichannel FIR smoother package
// Item types, field widths and register codes shared by the smoother modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mcfs_pkg;

	localparam int CHANNELS     = 3;
	localparam int SAMPLE_BITS  = 16;
	localparam int STAMP_BITS   = 32;
	localparam int COEF_BITS    = 16;
	localparam int TAPS_BITS    = 3;
	localparam int FRAC_BITS    = 15;
	localparam int MAX_TAPS_DEF = 7;

	localparam int REG_NUM_TAPS  = 0;
	localparam int REG_COEF_BASE = 1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic [STAMP_BITS-1:0]         stamp_t;

	localparam coef_t COEF_UNITY = {1'b0, {(COEF_BITS - 1){1'b1}}};

	typedef struct packed {
		logic    start_req;
		stamp_t  stamp;
		sample_t sample_0;
		sample_t sample_1;
		sample_t sample_2;
	} row_item_t;

	typedef struct packed {
		stamp_t  center_stamp;
		sample_t smoothed_0;
		sample_t smoothed_1;
		sample_t smoothed_2;
	} result_item_t;

endpackage

`default_nettype wire

@@ hdl/mcfs_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Smoother configuration registers
// Tap count and Q1.15 tap weights, with the tap count clamped to 1..MAX_TAPS.
// ----------------------------------------------------------------------------
`default_nettype none

module mcfs_cfg_regs import mcfs_pkg::*; #(
	parameter int MAX_TAPS = MAX_TAPS_DEF,
	localparam int IDX_BITS = $clog2(MAX_TAPS + 1),
	localparam int CNT_BITS = $clog2(MAX_TAPS + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_write,
	input  wire logic [IDX_BITS-1:0] cfg_index,
	input  wire logic [COEF_BITS-1:0] cfg_data,
	output logic      [CNT_BITS-1:0] taps,
	output coef_t                    coef [MAX_TAPS]
);

	logic [TAPS_BITS-1:0] num_taps_q;
	coef_t                coef_q [MAX_TAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_taps_q <= TAPS_BITS'(1);
			for (int k = 0; k < MAX_TAPS; k++) begin
				coef_q[k] <= (k == 0) ? COEF_UNITY : '0;
			end
		end else if (cfg_write) begin
			if (cfg_index == IDX_BITS'(REG_NUM_TAPS)) begin
				num_taps_q <= cfg_data[TAPS_BITS-1:0];
			end
			for (int k = 0; k < MAX_TAPS; k++) begin
				if (cfg_index == IDX_BITS'(REG_COEF_BASE + k)) begin
					coef_q[k] <= cfg_data;
				end
			end
		end
	end

	always_comb begin
		int unsigned t;
		t = int'(num_taps_q);
		if (t == 0) t = 1;
		if (t > MAX_TAPS) t = MAX_TAPS;
		taps = CNT_BITS'(t);
	end

	assign coef = coef_q;

endmodule

`default_nettype wire

@@ hdl/mcfs_delay_line.sv @@
// ----------------------------------------------------------------------------
// Smoother delay line
// Shift register of the newest rows and the record fill count; flags rows
// that complete a full window.
// ----------------------------------------------------------------------------
`default_nettype none

module mcfs_delay_line import mcfs_pkg::*; #(
	parameter int MAX_TAPS = MAX_TAPS_DEF,
	localparam int CNT_BITS = $clog2(MAX_TAPS + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire row_item_t           row,
	input  wire logic [CNT_BITS-1:0] taps,
	input  wire logic                take_s1,
	output logic                     valid_s1,
	output sample_t                  win_s1 [MAX_TAPS][CHANNELS],
	output stamp_t                   stamp_s1 [MAX_TAPS]
);

	logic [CNT_BITS-1:0] fill_q;
	logic [CNT_BITS-1:0] fill_next;
	sample_t             row_samples [CHANNELS];

	assign row_samples[0] = row.sample_0;
	assign row_samples[1] = row.sample_1;
	assign row_samples[2] = row.sample_2;

	always_comb begin
		if (row.start_req) begin
			fill_next = CNT_BITS'(1);
		end else if (fill_q < CNT_BITS'(MAX_TAPS)) begin
			fill_next = fill_q + CNT_BITS'(1);
		end else begin
			fill_next = fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			valid_s1 <= 1'b0;
		end else if (accept) begin
			fill_q   <= fill_next;
			valid_s1 <= (fill_next >= taps);
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// advance the window on every accepted row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < MAX_TAPS; p++) begin
				stamp_s1[p] <= '0;
				for (int c = 0; c < CHANNELS; c++) begin
					win_s1[p][c] <= '0;
				end
			end
		end else if (accept) begin
			for (int p = MAX_TAPS - 1; p > 0; p--) begin
				stamp_s1[p] <= stamp_s1[p-1];
				for (int c = 0; c < CHANNELS; c++) begin
					win_s1[p][c] <= win_s1[p-1][c];
				end
			end
			stamp_s1[0] <= row.stamp;
			for (int c = 0; c < CHANNELS; c++) begin
				win_s1[0][c] <= row_samples[c];
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_BITS'(MAX_TAPS))
		else $error("fill count above window depth");

	a_fill_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && row.start_req |=> fill_q == CNT_BITS'(1))
		else $error("start row did not restart fill count");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !row.start_req && fill_q < CNT_BITS'(MAX_TAPS)
		|=> fill_q == $past(fill_q) + CNT_BITS'(1))
		else $error("fill count did not advance");

	a_newest_row: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> win_s1[0][0] == $past(row.sample_0) && stamp_s1[0] == $past(row.stamp))
		else $error("newest window row does not hold the accepted item");

endmodule

`default_nettype wire

@@ hdl/mcfs_mac.sv @@
// ----------------------------------------------------------------------------
// Smoother multiply-accumulate
// Per-tap products, then sum, round half up, saturate, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcfs_mac import mcfs_pkg::*; #(
	parameter int MAX_TAPS = MAX_TAPS_DEF,
	localparam int CNT_BITS = $clog2(MAX_TAPS + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                valid_s1,
	input  wire sample_t             win_s1 [MAX_TAPS][CHANNELS],
	input  wire stamp_t              stamp_s1 [MAX_TAPS],
	input  wire logic [CNT_BITS-1:0] taps,
	input  wire coef_t               coef [MAX_TAPS],
	output logic                     take_s1,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output result_item_t             result
);

	localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_BITS  = PROD_BITS + $clog2(MAX_TAPS) + 1;
	localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(64'd1 << (FRAC_BITS - 1));
	localparam logic signed [ACC_BITS-1:0] SAT_HI =
		ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [ACC_BITS-1:0] SAT_LO = -SAT_HI - ACC_BITS'(1);

	logic                        valid_s2;
	logic signed [PROD_BITS-1:0] prod_s2 [MAX_TAPS][CHANNELS];
	stamp_t                      cstamp_s2;
	logic                        ready_s2;
	logic                        ready_s3;
	coef_t                       csel [MAX_TAPS];
	stamp_t                      cstamp;
	sample_t                     sat [CHANNELS];
	result_item_t                result_q;

	assign ready_s3 = !result_valid || !result_stall;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign take_s1  = ready_s2;

	// window position p takes the weight of row taps-1-p; positions past the window drop out
	always_comb begin
		for (int p = 0; p < MAX_TAPS; p++) begin
			csel[p] = '0;
			for (int j = 0; j < MAX_TAPS; j++) begin
				if (int'(taps) - 1 - p == j) csel[p] = coef[j];
			end
		end
		cstamp = stamp_s1[0];
		for (int p = 0; p < MAX_TAPS; p++) begin
			if (int'(taps >> 1) == p) cstamp = stamp_s1[p];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) result_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			cstamp_s2 <= cstamp;
			for (int p = 0; p < MAX_TAPS; p++) begin
				for (int c = 0; c < CHANNELS; c++) begin
					prod_s2[p][c] <= win_s1[p][c] * csel[p];
				end
			end
		end
	end

	always_comb begin
		logic signed [ACC_BITS-1:0] acc;
		logic signed [ACC_BITS-1:0] rnd;
		for (int c = 0; c < CHANNELS; c++) begin
			acc = '0;
			for (int p = 0; p < MAX_TAPS; p++) begin
				acc = acc + $signed({{(ACC_BITS - PROD_BITS){prod_s2[p][c][PROD_BITS-1]}},
					prod_s2[p][c]});
			end
			rnd = (acc + ROUND_HALF) >>> FRAC_BITS;
			if (rnd > SAT_HI) begin
				sat[c] = SAT_HI[SAMPLE_BITS-1:0];
			end else if (rnd < SAT_LO) begin
				sat[c] = SAT_LO[SAMPLE_BITS-1:0];
			end else begin
				sat[c] = rnd[SAMPLE_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			result_q.center_stamp <= cstamp_s2;
			result_q.smoothed_0   <= sat[0];
			result_q.smoothed_1   <= sat[1];
			result_q.smoothed_2   <= sat[2];
		end
	end

	assign result = result_q;

	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_valid && result_stall |=> valid_s2)
		else $error("product stage dropped an item behind a stalled result");

	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_valid && result_stall |-> !take_s1)
		else $error("delay line released while both stages are full");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(valid_s2))
		else $error("result raised without a product stage item");

endmodule

`default_nettype wire

@@ hdl/multichannel_fir_smoother.sv @@
// ----------------------------------------------------------------------------
// Multichannel FIR smoother
// Q1.15 FIR over the newest rows of a three-channel sample stream.
// ----------------------------------------------------------------------------
// The block takes one row per clock while row_stall is low and, once num_taps
// rows of the current record have arrived, gives one result per row, passing
// the delay line, per-tap product and sum/round/saturate result registers. Rows
// that only fill the window give no result. coef_0 weights the oldest row of
// the window; result stall backs up through the two stages and stalls the row
// side only when both are full. The user must write registers only while the
// block is idle; the block does not enforce this.
`default_nettype none

module multichannel_fir_smoother import mcfs_pkg::*; #(
	parameter int MAX_TAPS = MAX_TAPS_DEF,
	localparam int IDX_BITS = $clog2(MAX_TAPS + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [IDX_BITS-1:0]  cfg_index,
	input  wire logic [COEF_BITS-1:0] cfg_data,
	input  wire logic                 row_valid,
	output logic                      row_stall,
	input  wire row_item_t            row,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output result_item_t              result
);

	localparam int CNT_BITS = $clog2(MAX_TAPS + 1);

	logic [CNT_BITS-1:0] taps;
	coef_t               coef [MAX_TAPS];
	logic                accept;
	logic                valid_s1;
	logic                take_s1;
	sample_t             win_s1 [MAX_TAPS][CHANNELS];
	stamp_t              stamp_s1 [MAX_TAPS];

	assign row_stall = valid_s1 && !take_s1;
	assign accept    = row_valid && !row_stall;

	mcfs_cfg_regs #(.MAX_TAPS(MAX_TAPS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.taps      (taps),
		.coef      (coef)
	);

	mcfs_delay_line #(.MAX_TAPS(MAX_TAPS)) u_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.row      (row),
		.taps     (taps),
		.take_s1  (take_s1),
		.valid_s1 (valid_s1),
		.win_s1   (win_s1),
		.stamp_s1 (stamp_s1)
	);

	mcfs_mac #(.MAX_TAPS(MAX_TAPS)) u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.win_s1       (win_s1),
		.stamp_s1     (stamp_s1),
		.taps         (taps),
		.coef         (coef),
		.take_s1      (take_s1),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multichannel FIR smoother testbench
// Feeds rows through the smoother with random source gaps and result stalls.
// A local copy of the tap window predicts every result, which is checked field
// by field. A short directed table covers rounding, saturation, warm-up,
// record restarts and tap count changes. Random phases sweep tap counts and
// weight sets.
// ----------------------------------------------------------------------------
module testbench;
	import mcfs_pkg::*;

	localparam int TAPS_MAX       = 7;
	localparam int PIPE_DRAIN     = 8;
	localparam int IDLE_LIMIT     = 2000;
	localparam int RAND_PHASES    = 10;
	localparam int ROWS_PER_PHASE = 75;
	localparam int REPORT_MAX     = 10;
	localparam longint SAT_HI     = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint SAT_LO     = -SAT_HI - 1;
	localparam longint ROUND_HALF = longint'(1) << (FRAC_BITS - 1);

	typedef enum bit {STEP_ROW, STEP_REG} step_kind_t;

	typedef struct {
		step_kind_t           kind;
		int                   reg_idx;
		logic [COEF_BITS-1:0] reg_data;
		row_item_t            row;
		bit                   typed;
		bit                   typed_has;
		result_item_t         typed_res;
	} dir_step_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [2:0]           cfg_index = '0;
	logic [COEF_BITS-1:0] cfg_data = '0;
	logic                 row_valid = 1'b0;
	logic                 row_stall;
	row_item_t            row = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_item_t         result;

	logic [TAPS_BITS-1:0] tap_setting;
	coef_t                weight [TAPS_MAX];
	sample_t              win_sample [TAPS_MAX][CHANNELS];
	stamp_t               win_stamp [TAPS_MAX];
	int                   rows_in_record;

	result_item_t pending_results [$];
	dir_step_t    dir_steps [$];
	result_item_t want_res;
	int           errors = 0;
	int           idle_cycles = 0;
	int           stall_left = 0;
	int           quiet_left = 0;
	int           stall_roll;
	bit           gappy = 1'b0;
	stamp_t       stamp_ctr;

	multichannel_fir_smoother dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.row_valid(row_valid),
		.row_stall(row_stall),
		.row(row),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit smooth_row(input row_item_t r, output result_item_t res);
		sample_t fresh [CHANNELS];
		sample_t chan_out [CHANNELS];
		int      n;
		int      left;
		longint  acc;
		longint  q;
		fresh[0] = r.sample_0;
		fresh[1] = r.sample_1;
		fresh[2] = r.sample_2;
		for (int k = TAPS_MAX - 1; k > 0; k--) begin
			win_stamp[k] = win_stamp[k - 1];
			for (int c = 0; c < CHANNELS; c++)
				win_sample[k][c] = win_sample[k - 1][c];
		end
		win_stamp[0] = r.stamp;
		for (int c = 0; c < CHANNELS; c++)
			win_sample[0][c] = fresh[c];
		if (r.start_req)
			rows_in_record = 1;
		else if (rows_in_record < TAPS_MAX)
			rows_in_record++;
		n = (tap_setting == 0) ? 1 : int'(tap_setting);
		res = '0;
		if (rows_in_record < n)
			return 1'b0;
		left = (n % 2 == 1) ? n / 2 : n / 2 - 1;
		res.center_stamp = win_stamp[n - 1 - left];
		for (int c = 0; c < CHANNELS; c++) begin
			acc = 0;
			for (int j = 0; j < n; j++)
				acc += longint'(win_sample[n - 1 - j][c]) * longint'(weight[j]);
			q = (acc + ROUND_HALF) >>> FRAC_BITS;
			if (q > SAT_HI)
				q = SAT_HI;
			else if (q < SAT_LO)
				q = SAT_LO;
			chan_out[c] = sample_t'(q);
		end
		res.smoothed_0 = chan_out[0];
		res.smoothed_1 = chan_out[1];
		res.smoothed_2 = chan_out[2];
		return 1'b1;
	endfunction

	function automatic void queue_step(input dir_step_t s);
		dir_steps = {dir_steps, s};
	endfunction

	function automatic dir_step_t reg_step(input int idx, input logic [COEF_BITS-1:0] data);
		dir_step_t s;
		s = '{kind: STEP_REG, default: '0};
		s.reg_idx = idx;
		s.reg_data = data;
		return s;
	endfunction

	function automatic dir_step_t free_row(input logic start, input stamp_t stamp,
			input int s0, input int s1, input int s2);
		dir_step_t s;
		s = '{kind: STEP_ROW, default: '0};
		s.row.start_req = start;
		s.row.stamp = stamp;
		s.row.sample_0 = sample_t'(s0);
		s.row.sample_1 = sample_t'(s1);
		s.row.sample_2 = sample_t'(s2);
		return s;
	endfunction

	function automatic dir_step_t fixed_row(input logic start, input stamp_t stamp,
			input int s0, input int s1, input int s2, input bit has,
			input stamp_t cs, input int r0, input int r1, input int r2);
		dir_step_t s;
		s = free_row(start, stamp, s0, s1, s2);
		s.typed = 1'b1;
		s.typed_has = has;
		s.typed_res.center_stamp = cs;
		s.typed_res.smoothed_0 = sample_t'(r0);
		s.typed_res.smoothed_1 = sample_t'(r1);
		s.typed_res.smoothed_2 = sample_t'(r2);
		return s;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (!gappy || roll < 70)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic sample_t random_sample(input int style);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 6)
			return sample_t'(SAT_HI);
		if (roll < 12)
			return sample_t'(SAT_LO);
		case (style)
			0: return sample_t'($urandom);
			1: return sample_t'(int'($urandom_range(0, 600)) - 300);
			default: begin
				case ($urandom_range(0, 3))
					0: return sample_t'(0);
					1: return sample_t'(1);
					2: return sample_t'(-1);
					default: return sample_t'($urandom);
				endcase
			end
		endcase
	endfunction

	function automatic row_item_t random_row(input int style, input bit first);
		row_item_t r;
		r.start_req = first ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 24) == 0);
		if ($urandom_range(0, 3) == 0) begin
			r.stamp = $urandom;
		end else begin
			stamp_ctr = stamp_ctr + $urandom_range(1, 3);
			r.stamp = stamp_ctr;
		end
		r.sample_0 = random_sample(style);
		r.sample_1 = random_sample(style);
		r.sample_2 = random_sample(style);
		return r;
	endfunction

	task automatic write_reg(input int idx, input logic [COEF_BITS-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx[2:0];
		cfg_data <= data;
		if (idx == REG_NUM_TAPS)
			tap_setting = data[TAPS_BITS-1:0];
		else
			weight[idx - REG_COEF_BASE] = coef_t'(data);
		@(posedge clk);
	endtask

	task automatic send_row(input row_item_t r, input bit typed, input bit typed_has,
			input result_item_t typed_res);
		result_item_t res;
		bit           has;
		int           gap;
		cfg_write <= 1'b0;
		row <= r;
		row_valid <= 1'b1;
		do
			@(posedge clk);
		while (row_stall !== 1'b0);
		has = smooth_row(r, res);
		if (typed) begin
			has = typed_has;
			res = typed_res;
		end
		if (has)
			pending_results = {pending_results, res};
		gap = pick_gap();
		if (gap > 0) begin
			row_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic hold_until_drained();
		row_valid <= 1'b0;
		cfg_write <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic settle();
		hold_until_drained();
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic pick_config(input int phase);
		int                   taps;
		int                   n;
		int                   style;
		logic [COEF_BITS-1:0] w;
		case (phase)
			0: taps = TAPS_MAX;
			1: taps = 1;
			2: taps = 0;
			default: taps = $urandom_range(0, TAPS_MAX);
		endcase
		n = (taps == 0) ? 1 : taps;
		style = $urandom_range(0, 3);
		w = COEF_BITS'($urandom);
		w[TAPS_BITS-1:0] = taps[TAPS_BITS-1:0];
		write_reg(REG_NUM_TAPS, w);
		for (int k = 0; k < TAPS_MAX; k++) begin
			case (style)
				0: w = COEF_BITS'($urandom);
				1: w = COEF_BITS'($urandom_range(0, 32767 / n));
				2: begin
					case ($urandom_range(0, 4))
						0: w = COEF_UNITY;
						1: w = 16'h8000;
						2: w = 16'h0000;
						3: w = 16'h0001;
						default: w = 16'hFFFF;
					endcase
				end
				default: w = (k == n / 2) ? COEF_UNITY : '0;
			endcase
			write_reg(REG_COEF_BASE + k, w);
		end
	endtask

	task automatic check_field(input string what, input logic [STAMP_BITS-1:0] want_v,
			input logic [STAMP_BITS-1:0] got_v);
		if (got_v !== want_v) begin
			errors++;
			if (errors <= REPORT_MAX)
				$display("%s mismatch: expected %h, got %h", what, want_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && result_stall == 1'b0) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected result item: %h", result);
			end else begin
				want_res = pending_results.pop_front();
				check_field("center_stamp", want_res.center_stamp, result.center_stamp);
				check_field("smoothed_0", {16'h0000, want_res.smoothed_0},
					{16'h0000, result.smoothed_0});
				check_field("smoothed_1", {16'h0000, want_res.smoothed_1},
					{16'h0000, result.smoothed_1});
				check_field("smoothed_2", {16'h0000, want_res.smoothed_2},
					{16'h0000, result.smoothed_2});
			end
		end
	end

	always @(posedge clk) begin
		if (quiet_left > 0) begin
			quiet_left = quiet_left - 1;
			result_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			result_stall <= 1'b1;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 2) begin
				quiet_left = $urandom_range(60, 150);
				result_stall <= 1'b0;
			end else if (stall_roll < 20) begin
				stall_left = $urandom_range(0, 2);
				result_stall <= 1'b1;
			end else if (stall_roll < 23) begin
				stall_left = $urandom_range(10, 40);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
		if ((row_valid && !row_stall) || (result_valid && !result_stall) || cfg_write)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		int style;
		tap_setting = 1;
		rows_in_record = 0;
		for (int k = 0; k < TAPS_MAX; k++) begin
			weight[k] = '0;
			win_stamp[k] = '0;
			for (int c = 0; c < CHANNELS; c++)
				win_sample[k][c] = '0;
		end
		weight[0] = COEF_UNITY;
		stamp_ctr = $urandom;

		queue_step(fixed_row(1'b0, 32'h0000_0000, 0, 0, 0,
			1'b1, 32'h0000_0000, 0, 0, 0));
		queue_step(fixed_row(1'b0, 32'hFFFF_FFFF, 32767, -32768, 0,
			1'b1, 32'hFFFF_FFFF, 32766, -32767, 0));
		queue_step(reg_step(REG_COEF_BASE, 16'h8000));
		queue_step(reg_step(REG_NUM_TAPS, 16'h0000));
		queue_step(fixed_row(1'b1, 32'hA5A5_A5A5, -32768, 32767, 1,
			1'b1, 32'hA5A5_A5A5, 32767, -32767, -1));
		queue_step(reg_step(REG_COEF_BASE, 16'h4000));
		queue_step(fixed_row(1'b0, 32'h1234_5678, 1, -1, 3,
			1'b1, 32'h1234_5678, 1, 0, 2));
		queue_step(reg_step(REG_NUM_TAPS, 16'h0007));
		for (int k = 0; k < TAPS_MAX; k++)
			queue_step(reg_step(REG_COEF_BASE + k, COEF_UNITY));
		for (int k = 1; k <= TAPS_MAX; k++)
			queue_step(fixed_row(k == 1, k, 32767, -32768, 0,
				k == TAPS_MAX, 4, 32767, -32768, 0));
		queue_step(fixed_row(1'b1, 32'd8, 1000, -1000, 5, 1'b0, 0, 0, 0, 0));
		queue_step(reg_step(REG_NUM_TAPS, 16'h0004));
		for (int k = 0; k < 4; k++)
			queue_step(reg_step(REG_COEF_BASE + k, 16'h2000));
		queue_step(free_row(1'b0, 32'd9, 12000, -7000, 32767));
		queue_step(free_row(1'b0, 32'd10, -32768, 300, -1));
		queue_step(free_row(1'b0, 32'd11, 4095, -4096, 77));
		queue_step(free_row(1'b0, 32'd12, 32767, 32767, -32768));
		queue_step(reg_step(REG_NUM_TAPS, 16'h0002));
		queue_step(reg_step(REG_COEF_BASE, 16'h6000));
		queue_step(reg_step(REG_COEF_BASE + 1, 16'hE000));
		queue_step(free_row(1'b0, 32'd13, -20000, 15000, 2));
		queue_step(free_row(1'b1, 32'd14, 32767, -32768, -3));
		queue_step(free_row(1'b0, 32'd15, -32768, 32767, 9999));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gappy = 1'b1;
		foreach (dir_steps[i]) begin
			if (dir_steps[i].kind == STEP_REG) begin
				if (i > 0 && dir_steps[i - 1].kind == STEP_ROW)
					settle();
				write_reg(dir_steps[i].reg_idx, dir_steps[i].reg_data);
			end else begin
				send_row(dir_steps[i].row, dir_steps[i].typed, dir_steps[i].typed_has,
					dir_steps[i].typed_res);
			end
		end
		settle();

		for (int p = 0; p < RAND_PHASES; p++) begin
			pick_config(p);
			gappy = ($urandom_range(0, 3) != 0);
			style = $urandom_range(0, 2);
			for (int k = 0; k < ROWS_PER_PHASE; k++) begin
				// hold the source until the pipeline empties once
				if (p == 3 && k == ROWS_PER_PHASE / 2)
					hold_until_drained();
				send_row(random_row(style, k == 0), 1'b0, 1'b0, '0);
			end
			settle();
		end

		if (errors == 0 && pending_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
